// ===== rtl/fba_pkg.sv =====
// Shared constants and types for the frame bitmap allocator.
package fba_pkg;

  localparam int NUM_FRAMES_DEF = 1024;
  localparam int WORD_W         = 16;
  localparam int BIT_W          = $clog2(WORD_W);
  localparam int FIELD_W        = 11;
  localparam int FRAME_W        = 10;
  localparam int ACT_W          = 2;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 16;

  localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd2;

  localparam logic [WORD_W-1:0] TOP_BIT  = 16'h8000;
  localparam logic [WORD_W-1:0] ALL_ONES = 16'hFFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN,
    S_FINISH
  } fba_state_t;

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
// First-fit frame allocator over a bitmap held in a single-port-pair RAM.
// The bitmap holds one bit per frame, NUM_FRAMES/16 words (W, rounded up) of 16 bits,
// frame i in word i/16 at bit 15-(i%16), 1 meaning free. Replace, add and
// allocate walk the RAM one word per cycle: a replace or add transfer
// rewrites every word, an allocate transfer stops at the first word holding
// a free frame (all W words when none is free), and an unused action code
// goes straight to a not-found result. The walk rate is set by the one
// read and one write port of the bitmap RAM. After reset the block clears
// the RAM in one pass during which s_tready is low.
// One item is in work at a time; the result register lets the next item be
// accepted while a result still waits on the master side.
module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fba_pkg::IN_TDATA_W-1:0]  s_tdata,  // first_frame, end_frame, zero fill
  input  logic [fba_pkg::ACT_W-1:0]       s_tuser,  // action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fba_pkg::OUT_TDATA_W-1:0] m_tdata,  // frame, zero fill
  output logic                           m_tuser   // found
);
  import fba_pkg::*;

  localparam int WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NCW   = $clog2(NUM_FRAMES + 1);
  localparam int CW    = (NCW > FIELD_W) ? NCW : FIELD_W;
  localparam int WW    = CW - BIT_W;
  localparam int SH_W  = BIT_W + 1;

  fba_state_t state, state_next;

  logic [ACT_W-1:0]  act;
  logic              emit;
  logic [WW-1:0]     first_w, end_w;
  logic [BIT_W-1:0]  first_b, end_b;
  logic [AW:0]       rd_ptr;
  logic              p_valid;
  logic [AW-1:0]     p_addr;
  logic [WORD_W-1:0] rdata, wdata, mask;
  logic              wr_en, issue, hit, last_word;
  logic [BIT_W-1:0]  hit_bit;
  logic [SH_W-1:0]   lo, hi;
  logic [WW-1:0]     w_ext;
  logic [CW-1:0]     first_ext, end_ext, end_clip;
  logic [FRAME_W-1:0] res_frame;
  logic              res_found;

  fba_bitmap_ram #(
    .DEPTH(WORDS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(p_addr),
    .wdata(wdata),
    .re   (issue),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rdata)
  );

  // Range bounds of the incoming transfer, end clipped to the table size.
  assign first_ext = CW'(s_tdata[FIELD_W-1:0]);
  assign end_ext   = CW'(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign end_clip  = (end_ext > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : end_ext;

  assign issue     = ((state == S_SWEEP) || (state == S_SCAN)) && (rd_ptr < (AW+1)'(WORDS));
  assign last_word = (p_addr == AW'(WORDS - 1));
  assign w_ext     = WW'(p_addr);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser) inside
            ACT_REPLACE, ACT_ADD: state_next = S_SWEEP;
            ACT_ALLOC:            state_next = S_SCAN;
            default:              state_next = S_FINISH;
          endcase
        end
      end
      S_SWEEP: begin
        if (p_valid && last_word) begin
          state_next = emit ? S_FINISH : S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit || (p_valid && last_word)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Word mask, first-free search and write-back data.
  always_comb begin
    if (w_ext == first_w) begin
      lo = {1'b0, first_b};
    end else if (w_ext < first_w) begin
      lo = SH_W'(WORD_W);
    end else begin
      lo = '0;
    end
    if (w_ext == end_w) begin
      hi = {1'b0, end_b};
    end else if (w_ext < end_w) begin
      hi = SH_W'(WORD_W);
    end else begin
      hi = '0;
    end
    mask = (ALL_ONES >> lo) & ~(ALL_ONES >> hi);

    // Lowest frame number sits in the highest bit, so the last match wins.
    hit_bit = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (rdata[WORD_W-1-j]) begin
        hit_bit = BIT_W'(j);
      end
    end

    s_tready = (state == S_IDLE);
    wr_en    = 1'b0;
    hit      = 1'b0;
    wdata    = '0;
    unique case (state)
      S_SWEEP: begin
        wr_en = p_valid;
        wdata = ((act == ACT_ADD) ? rdata : '0) | mask;
      end
      S_SCAN: begin
        hit   = p_valid && (rdata != '0);
        wr_en = hit;
        wdata = rdata & ~(TOP_BIT >> hit_bit);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Control state. Reset starts a replace walk with an empty range and no
  // result, which clears the whole bitmap.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      rd_ptr  <= '0;
      p_valid <= 1'b0;
      emit    <= 1'b0;
      act     <= ACT_REPLACE;
      first_w <= '0;
      end_w   <= '0;
      first_b <= '0;
      end_b   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        rd_ptr  <= '0;
        p_valid <= 1'b0;
        if (s_tvalid) begin
          emit    <= 1'b1;
          act     <= s_tuser;
          first_w <= first_ext[CW-1:BIT_W];
          first_b <= first_ext[BIT_W-1:0];
          end_w   <= end_clip[CW-1:BIT_W];
          end_b   <= end_clip[BIT_W-1:0];
        end
      end else begin
        p_valid <= issue;
        if (issue) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if ((state == S_FINISH) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      p_addr <= rd_ptr[AW-1:0];
    end
    if ((state == S_IDLE) && s_tvalid) begin
      res_frame <= '0;
      res_found <= 1'b0;
    end else if (hit) begin
      res_frame <= FRAME_W'({p_addr, hit_bit});
      res_found <= 1'b1;
    end
    if ((state == S_FINISH) && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_TDATA_W'(res_frame);
      m_tuser <= res_found;
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("bitmap written while idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result appeared outside the finish step");

  a_claim_one_bit: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == S_SCAN)) |-> ($countones(rdata ^ wdata) == 1))
    else $error("allocation changed other than one bit");

  a_miss_zero_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("frame not zero without a claimed frame");

endmodule

// ===== rtl/fba_bitmap_ram.sv =====
// Bitmap word store: one write port, one read port, registered read data.
module fba_bitmap_ram #(
  parameter int DEPTH = fba_pkg::NUM_FRAMES_DEF / fba_pkg::WORD_W,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [fba_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [fba_pkg::WORD_W-1:0] rdata
);
  import fba_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the first-fit frame bitmap allocator.
module tb_top;
  import fba_pkg::*;

  localparam int NFRAMES = NUM_FRAMES_DEF;
  localparam int NWORDS = (NFRAMES + WORD_W - 1) / WORD_W;
  localparam int RANDOM_ITEMS = 1830;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
  localparam logic [FIELD_W-1:0] RANGE_END = FIELD_W'(NFRAMES);
  localparam logic [FIELD_W-1:0] RANGE_LAST = FIELD_W'(NFRAMES - 1);
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               found;
  } alloc_result_t;

  // Mirrors the free-frame table and keeps the results still owed by the block.
  class alloc_scoreboard;
    logic [WORD_W-1:0] free_map [NWORDS];
    alloc_result_t awaited [$];
    int mismatches;
    int n_replace, n_add, n_claimed, n_exhausted, n_unused, n_checked;

    function new();
      foreach (free_map[i]) free_map[i] = '0;
      mismatches = 0;
      n_replace = 0;
      n_add = 0;
      n_claimed = 0;
      n_exhausted = 0;
      n_unused = 0;
      n_checked = 0;
    endfunction

    // Frames at or above the table size are dropped, so the range is clipped.
    function void mark_free(int unsigned first, int unsigned last_excl);
      int unsigned f;
      if (last_excl > NFRAMES) last_excl = NFRAMES;
      for (f = first; f < last_excl; f++)
        free_map[f / WORD_W] |= TOP_BIT >> (f % WORD_W);
    endfunction

    function alloc_result_t claim_lowest();
      alloc_result_t r;
      logic [WORD_W-1:0] b;
      r = '0;
      for (int f = 0; f < NFRAMES; f++) begin
        b = TOP_BIT >> (f % WORD_W);
        if ((free_map[f / WORD_W] & b) != '0) begin
          free_map[f / WORD_W] &= ~b;
          r.frame = FRAME_W'(f);
          r.found = 1'b1;
          return r;
        end
      end
      return r;
    endfunction

    function void note_item(logic [ACT_W-1:0] act, logic [FIELD_W-1:0] ff,
                            logic [FIELD_W-1:0] ef);
      alloc_result_t r;
      r = '0;
      case (act)
        ACT_REPLACE: begin
          foreach (free_map[i]) free_map[i] = '0;
          mark_free(32'(ff), 32'(ef));
          n_replace++;
        end
        ACT_ADD: begin
          mark_free(32'(ff), 32'(ef));
          n_add++;
        end
        ACT_ALLOC: begin
          r = claim_lowest();
          if (r.found) n_claimed++;
          else n_exhausted++;
        end
        default: n_unused++;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      alloc_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual frame %0d found %0b",
                 $time, tdata[FRAME_W-1:0], tuser);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (tdata[FRAME_W-1:0] !== want.frame) begin
        $display("%0t: frame mismatch, expected %0d, actual %0d",
                 $time, want.frame, tdata[FRAME_W-1:0]);
        mismatches++;
      end
      if (tuser !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, tuser);
        mismatches++;
      end
      if (tdata[OUT_TDATA_W-1:FRAME_W] !== '0) begin
        $display("%0t: tdata fill mismatch, expected 0, actual %0h",
                 $time, tdata[OUT_TDATA_W-1:FRAME_W]);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [ACT_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  int sent = 0;
  alloc_scoreboard sb = new();

  always #2 clk = ~clk;

  frame_bitmap_allocator #(.NUM_FRAMES(NFRAMES)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Offers one request and returns at the edge where the transfer happens.
  task automatic offer(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] ff,
                       input logic [FIELD_W-1:0] ef);
    if (!quiet && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 120)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {{(IN_TDATA_W - 2 * FIELD_W){1'b0}}, ef, ff};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(act, ff, ef);
    sent++;
  endtask

  // Mostly short ranges so that allocation bursts run the table dry now and then.
  function automatic void pick_range(output logic [FIELD_W-1:0] ff,
                                     output logic [FIELD_W-1:0] ef);
    int unsigned lo;
    lo = $urandom_range(0, NFRAMES - 1);
    case ($urandom_range(0, 9)) inside
      [0:5]: begin
        ff = FIELD_W'(lo);
        ef = FIELD_W'(lo + $urandom_range(0, 40));
      end
      6: begin
        ff = FIELD_W'($urandom_range(0, NFRAMES));
        ef = FIELD_W'($urandom_range(ff, NFRAMES));
      end
      7: begin
        ff = FIELD_W'(lo);
        ef = FIELD_W'($urandom_range(0, lo));
      end
      8: begin
        ff = FIELD_W'($urandom_range(NFRAMES - 100, FIELD_MAX));
        ef = FIELD_W'($urandom_range(NFRAMES - 50, FIELD_MAX));
      end
      default: begin
        ff = FIELD_W'($urandom);
        ef = FIELD_W'($urandom);
      end
    endcase
  endfunction

  initial begin
    logic [FIELD_W-1:0] ff, ef;
    int base;
    int n;
    int burst;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    offer(ACT_ALLOC, 0, 0);
    offer(ACT_REPLACE, 0, RANGE_END);
    offer(ACT_ALLOC, FIELD_MAX, FIELD_MAX);
    offer(ACT_ALLOC, 0, 0);
    offer(ACT_REPLACE, 5, 5);
    offer(ACT_ALLOC, 0, 0);
    offer(ACT_ADD, 1020, FIELD_MAX);
    offer(ACT_ADD, 10, 3);
    repeat (5) offer(ACT_ALLOC, 0, 0);
    offer(ACT_REPLACE, FIELD_MAX, FIELD_MAX);
    offer(ACT_UNUSED, FIELD_MAX, FIELD_MAX);
    offer(ACT_ADD, 15, 17);
    offer(ACT_UNUSED, 0, 0);
    repeat (3) offer(ACT_ALLOC, 0, 0);
    offer(ACT_ADD, RANGE_LAST, RANGE_END);
    offer(ACT_ALLOC, 0, 0);
    offer(ACT_ADD, RANGE_END, FIELD_MAX);
    offer(ACT_ALLOC, 0, 0);

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      n = sent - base;
      quiet = (n >= 600 && n < 900);
      if (!held && n >= 300) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && n >= 1200) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      pick_range(ff, ef);
      if ($urandom_range(0, 9) == 0) begin
        offer(ACT_W'($urandom_range(0, 3)), ff, ef);
      end else begin
        offer(($urandom_range(0, 4) < 2) ? ACT_REPLACE : ACT_ADD, ff, ef);
        burst = $urandom_range(1, 20);
        repeat (burst) offer(ACT_ALLOC, FIELD_W'($urandom), FIELD_W'($urandom));
      end
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d replace, %0d add, %0d unused-code.",
             sent, sb.n_replace, sb.n_add, sb.n_unused);
    $display("Allocations: %0d claimed a frame, %0d found the table empty; %0d results checked.",
             sb.n_claimed, sb.n_exhausted, sb.n_checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: checks each transfer and throttles m_tready, with one long hold.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fba_pkg.sv
rtl/fba_bitmap_ram.sv
rtl/frame_bitmap_allocator.sv
tb/tb_top.sv
